// File: rtl/gae_advantage_scan_defines.svh
// ----------------------------------------------------------------------------
// gae_advantage_scan_defines
// assertion macros used by the advantage scan
// ----------------------------------------------------------------------------
`ifndef GAE_ADVANTAGE_SCAN_DEFINES_SVH
`define GAE_ADVANTAGE_SCAN_DEFINES_SVH

// same-cycle implication
`define GAE_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define GAE_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/gae_pkg.sv
// ----------------------------------------------------------------------------
// gae_pkg
// types, constants and helper functions of the advantage scan
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gae_pkg;

  localparam int VALUE_W   = 32;
  localparam int SUM_W     = 48;
  localparam int GAIN_W    = 17;
  localparam int SCALE_W   = 32;
  localparam int CLIP_W    = 31;
  localparam int KIND_W    = 2;
  localparam int FRAC_W    = 17;
  localparam int FRAC_BITS = 16;
  localparam int Q_SHIFT   = 16;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  localparam int MUL_W  = VALUE_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int WIDE_W = PROD_W - Q_SHIFT;
  localparam int TERM_W = VALUE_W + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS);

  localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << Q_SHIFT;
  localparam logic [FRAC_W-1:0] FRAC_ONE = FRAC_W'(1) << FRAC_BITS;

  localparam logic [GAIN_W-1:0]  DISCOUNT_RST    = GAIN_W'(64881);
  localparam logic [GAIN_W-1:0]  TRACE_DECAY_RST = GAIN_W'(62259);

  localparam logic signed [WIDE_W-1:0] SAT_HI =
    {{(WIDE_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] SAT_LO = ~SAT_HI;

  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TRUNC = 2'd2;

  localparam logic [1:0] REG_DISCOUNT    = 2'd0;
  localparam logic [1:0] REG_TRACE_DECAY = 2'd1;
  localparam logic [1:0] REG_SCALE       = 2'd2;
  localparam logic [1:0] REG_CLIP        = 2'd3;

  typedef struct packed {
    logic signed [VALUE_W-1:0] reward;
    logic signed [VALUE_W-1:0] value_pred;
    logic signed [VALUE_W-1:0] bootstrap_value;
    logic signed [VALUE_W-1:0] trunc_value;
    logic [KIND_W-1:0]         terminal_kind;
    logic                      first;
    logic                      last;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] advantage;
    logic signed [VALUE_W-1:0] target_value;
    logic signed [VALUE_W-1:0] return_value;
    logic [FRAC_W-1:0]         clip_fraction;
    logic                      batch_end;
  } out_item_t;

  typedef struct packed {
    logic signed [MUL_W-1:0] a;
    logic signed [MUL_W-1:0] b;
  } mul_op_t;

  typedef struct packed {
    logic busy;
    logic done;
  } frac_sts_t;

  function automatic logic signed [VALUE_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] r;
    r = v;
    if (v > SAT_HI) r = SAT_HI;
    if (v < SAT_LO) r = SAT_LO;
    return r[VALUE_W-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] abs_val(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W-1:0] u;
    u = v;
    return v[VALUE_W-1] ? (~u) + 1'b1 : u;
  endfunction

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [VALUE_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + (SUM_W+1)'(b);
    return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
  endfunction

endpackage

// File: rtl/gae_mul.sv
// ----------------------------------------------------------------------------
// gae_mul
// shared signed multiplier, registered product, floor shift to q34.16
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gae_mul
  import gae_pkg::*;
(
  input  logic                     clk,
  input  mul_op_t                  op,
  output logic signed [WIDE_W-1:0] res
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op.a * op.b;
  end

  assign res = prod_r[PROD_W-1:Q_SHIFT];

endmodule

// File: rtl/gae_frac.sv
// ----------------------------------------------------------------------------
// gae_frac
// bit-serial fraction unit, floor(num * 2^16 / den) for num <= den
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gae_frac
  import gae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  num,
  input  logic [SUM_W-1:0]  den,
  output logic [FRAC_W-1:0] quot,
  output frac_sts_t         sts
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0] rem_r;
  logic [FRAC_W-1:0] q_r;
  logic [SUM_W:0]   dbl;
  logic             ge;

  assign dbl = {rem_r, 1'b0};
  assign ge  = dbl >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= num < den;
        done_r <= num >= den;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(FRAC_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      q_r   <= (num >= den) ? FRAC_ONE : '0;
    end else if (busy_r) begin
      rem_r <= ge ? dbl[SUM_W-1:0] - den : dbl[SUM_W-1:0];
      q_r   <= {q_r[FRAC_W-2:0], ge};
    end
  end

  assign quot     = q_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

// File: rtl/gae_advantage_scan.sv
// Backward GAE scan over a rollout fed latest step first. Each item is worked
// by a small sequencer around one shared multiplier that forms, in turn,
// gamma*lambda, the scaled reward, the bootstrap term and the two recurrence
// terms; the next item is accepted only once this one is done and the
// output register is free to take its result. On an item marked last with
// scaling and clipping on and a nonzero reward sum, the clip fraction comes
// from a bit-serial divider, which skips the serial steps when the clipped
// sum is zero. The input is stalled while an item is at work; the result
// sits in an output register and is taken independently of the input side.
// Configuration sits on an APB-style port at byte addresses 0, 4, 8 and 12.
// ----------------------------------------------------------------------------
// gae_advantage_scan
// generalized advantage estimation with reward scaling and clipping
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gae_advantage_scan_defines.svh"

module gae_advantage_scan
  import gae_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_GL   = 9'b000000010,
    ST_RS   = 9'b000000100,
    ST_NV   = 9'b000001000,
    ST_ADV  = 9'b000010000,
    ST_RET  = 9'b000100000,
    ST_OUT  = 9'b001000000,
    ST_DIV  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [GAIN_W-1:0]  discount_r;
  logic [GAIN_W-1:0]  trace_decay_r;
  logic [SCALE_W-1:0] scale_r;
  logic [CLIP_W-1:0]  clip_r;

  in_item_t                  in_r;
  logic [GAIN_W-1:0]         gl_r;
  logic signed [VALUE_W-1:0] cur_r;
  logic signed [VALUE_W-1:0] cur_sat_r;
  logic signed [TERM_W-1:0]  gnv_r;
  logic signed [VALUE_W-1:0] adv_r;
  logic signed [VALUE_W-1:0] ret_r;
  logic signed [VALUE_W-1:0] tgt_r;
  logic                      frac_use_r;
  logic signed [VALUE_W-1:0] prev_adv_r;
  logic signed [VALUE_W-1:0] prev_ret_r;
  logic signed [VALUE_W-1:0] next_val_r;
  logic [SUM_W-1:0]          abs_reward_sum_r;
  logic [SUM_W-1:0]          abs_clipped_sum_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;

  logic                      accept;
  logic                      cfg_wr;
  logic                      scale_on;
  logic                      clip_on;
  logic                      k_done;
  logic                      k_trunc;
  logic                      k_cont;
  logic [GAIN_W-1:0]         g;
  logic [GAIN_W-1:0]         l;
  mul_op_t                   mul_op;
  logic signed [WIDE_W-1:0]  mul_res;
  logic signed [VALUE_W-1:0] nv;
  logic signed [VALUE_W-1:0] scaled;
  logic signed [VALUE_W-1:0] cur_sat;
  logic signed [VALUE_W-1:0] cur_clip;
  logic signed [VALUE_W-1:0] clip_pos;
  logic signed [VALUE_W-1:0] clip_neg;
  logic signed [WIDE_W-1:0]  adv_sum;
  logic signed [WIDE_W-1:0]  ret_sum;
  logic signed [WIDE_W-1:0]  tgt_sum;
  logic                      frac_need;
  logic                      frac_start;
  logic [FRAC_W-1:0]         frac_q;
  frac_sts_t                 frac_sts;
  logic                      out_free;

  // configuration port
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      discount_r    <= DISCOUNT_RST;
      trace_decay_r <= TRACE_DECAY_RST;
      scale_r       <= '0;
      clip_r        <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_DISCOUNT:    discount_r    <= pwdata[GAIN_W-1:0];
        REG_TRACE_DECAY: trace_decay_r <= pwdata[GAIN_W-1:0];
        REG_SCALE:       scale_r       <= pwdata[SCALE_W-1:0];
        REG_CLIP:        clip_r        <= pwdata[CLIP_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DISCOUNT:    prdata = DATA_W'(discount_r);
      REG_TRACE_DECAY: prdata = DATA_W'(trace_decay_r);
      REG_SCALE:       prdata = DATA_W'(scale_r);
      REG_CLIP:        prdata = DATA_W'(clip_r);
    endcase
  end

  // decoded controls
  assign in_stall = (state_r != ST_IDLE) || !rst_n;
  assign accept   = in_valid && !in_stall;
  assign scale_on = scale_r != '0;
  assign clip_on  = clip_r != '0;
  assign k_done   = in_r.terminal_kind == KIND_DONE;
  assign k_trunc  = in_r.terminal_kind == KIND_TRUNC;
  assign k_cont   = !k_done && !k_trunc;
  assign g        = (discount_r > GAIN_ONE) ? GAIN_ONE : discount_r;
  assign l        = (trace_decay_r > GAIN_ONE) ? GAIN_ONE : trace_decay_r;
  assign nv       = k_trunc ? in_r.trunc_value : next_val_r;
  assign out_free = !out_valid_r || !out_stall;

  // shared multiplier operands
  always_comb begin
    mul_op = '0;
    unique case (state_r)
      ST_GL: begin
        mul_op.a = MUL_W'(g);
        mul_op.b = MUL_W'(l);
      end
      ST_RS: begin
        mul_op.a = MUL_W'(in_r.reward);
        mul_op.b = MUL_W'(scale_r);
      end
      ST_NV: begin
        mul_op.a = MUL_W'(g);
        mul_op.b = MUL_W'(nv);
      end
      ST_ADV: begin
        mul_op.a = MUL_W'(gl_r);
        mul_op.b = MUL_W'(prev_adv_r);
      end
      ST_RET: begin
        mul_op.a = MUL_W'(g);
        mul_op.b = MUL_W'(prev_ret_r);
      end
      default: mul_op = '0;
    endcase
  end

  gae_mul u_mul (
    .clk (clk),
    .op  (mul_op),
    .res (mul_res)
  );

  // reward scaling and clipping
  assign scaled   = sat_val(mul_res);
  assign cur_sat  = scale_on ? scaled : in_r.reward;
  assign clip_pos = VALUE_W'(clip_r);
  assign clip_neg = -clip_pos;

  always_comb begin
    cur_clip = cur_sat;
    if (scale_on && clip_on) begin
      if (cur_sat > clip_pos) cur_clip = clip_pos;
      if (cur_sat < clip_neg) cur_clip = clip_neg;
    end
  end

  // recurrence sums
  assign adv_sum = WIDE_W'(cur_r) - WIDE_W'(in_r.value_pred)
                 + (k_done ? '0 : WIDE_W'(gnv_r))
                 + (k_cont ? mul_res : '0);
  assign ret_sum = WIDE_W'(in_r.reward) + (k_cont ? mul_res : '0);
  assign tgt_sum = WIDE_W'(in_r.value_pred) + WIDE_W'(adv_r);

  assign frac_need = in_r.last && scale_on && clip_on && (abs_reward_sum_r != '0)
                   && (abs_clipped_sum_r <= abs_reward_sum_r);
  assign frac_start = (state_r == ST_OUT) && frac_need;

  gae_frac u_frac (
    .clk   (clk),
    .rst_n (rst_n),
    .start (frac_start),
    .num   (abs_reward_sum_r - abs_clipped_sum_r),
    .den   (abs_reward_sum_r),
    .quot  (frac_q),
    .sts   (frac_sts)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_GL;
      ST_GL:   state_nxt = ST_RS;
      ST_RS:   state_nxt = ST_NV;
      ST_NV:   state_nxt = ST_ADV;
      ST_ADV:  state_nxt = ST_RET;
      ST_RET:  state_nxt = ST_OUT;
      ST_OUT:  state_nxt = frac_need ? ST_DIV : ST_FIN;
      ST_DIV:  if (frac_sts.done) state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // running state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_adv_r        <= '0;
      prev_ret_r        <= '0;
      next_val_r        <= '0;
      abs_reward_sum_r  <= '0;
      abs_clipped_sum_r <= '0;
    end else begin
      if (accept && in_item.first) begin
        prev_adv_r        <= '0;
        prev_ret_r        <= '0;
        next_val_r        <= in_item.bootstrap_value;
        abs_reward_sum_r  <= '0;
        abs_clipped_sum_r <= '0;
      end
      if (state_r == ST_ADV) begin
        abs_reward_sum_r <= sat_add(abs_reward_sum_r, abs_val(cur_sat_r));
        if (scale_on && clip_on) begin
          abs_clipped_sum_r <= sat_add(abs_clipped_sum_r, abs_val(cur_r));
        end
      end
      if (state_r == ST_OUT) begin
        prev_adv_r <= adv_r;
        prev_ret_r <= sat_val(ret_sum);
        next_val_r <= in_r.value_pred;
      end
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (accept) in_r <= in_item;
    if (state_r == ST_RS) gl_r <= mul_res[GAIN_W-1:0];
    if (state_r == ST_NV) begin
      cur_sat_r <= cur_sat;
      cur_r     <= cur_clip;
    end
    if (state_r == ST_ADV) gnv_r <= mul_res[TERM_W-1:0];
    if (state_r == ST_RET) adv_r <= sat_val(adv_sum);
    if (state_r == ST_OUT) begin
      ret_r      <= sat_val(ret_sum);
      tgt_r      <= sat_val(tgt_sum);
      frac_use_r <= frac_need;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_item_r.advantage     <= adv_r;
      out_item_r.target_value  <= tgt_r;
      out_item_r.return_value  <= ret_r;
      out_item_r.clip_fraction <= frac_use_r ? frac_q : '0;
      out_item_r.batch_end     <= in_r.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // checks
  `GAE_ASSERT_NXT(a_accept_starts, accept, state_r == ST_GL, "accepted item did not start")
  `GAE_ASSERT_IMP(a_div_in_place, frac_sts.busy, state_r == ST_DIV, "divider busy out of turn")
  `GAE_ASSERT_IMP(a_sum_order, 1'b1, abs_clipped_sum_r <= abs_reward_sum_r, "clipped sum too large")
  `GAE_ASSERT_NXT(a_fin_holds, state_r == ST_FIN && out_valid_r && out_stall,
                  state_r == ST_FIN, "result overwrote a waiting item")

endmodule
